// File: hw/rtl/rirl_pkg.sv
// Shared types and codes for the ranked insert/remove list.
// No dependencies; the controller, datapath, top level and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package rirl_pkg;

  // Default capacity of the list.
  localparam int DEPTH_DEF = 64;

  // Field widths of the input and result beats.
  localparam int CMD_W  = 2;
  localparam int RANK_W = 7;
  localparam int ELEM_W = 8;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [RANK_W-1:0] rank;
    logic [ELEM_W-1:0] elem;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [ELEM_W-1:0] data_out;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_DRAIN,
    S_COMMIT,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_item;
    logic eval;
    logic start_shift;
    logic shift_step;
    logic commit;
    logic load_result;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             err;
    logic             no_shift;
    logic             shift_last;
    logic             slot_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/rirl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rirl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/rirl_ctrl.sv
// Controller state machine of the ranked insert/remove list.
// Depends on rirl_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module rirl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire rirl_pkg::dp_stat_t stat,
  output      rirl_pkg::dp_ctrl_t ctrl
);

  import rirl_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        ctrl.latch_item = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        ctrl.eval = 1'b1;
        // Errors, single-entry commands and tail operations need no shift.
        if (stat.err || stat.no_shift ||
            (stat.cmd inside {CMD_READ, CMD_REPLACE})) begin
          state_next = S_COMMIT;
        end else begin
          ctrl.start_shift = 1'b1;
          state_next       = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctrl.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last moved entry is written back in this cycle.
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          ctrl.load_result = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/rirl_dp.sv
// Datapath of the ranked insert/remove list: entry RAM, fill count,
// shift address walker and result register. Depends on rirl_pkg and rirl_ram.
`timescale 1ns / 1ps
`default_nettype none

module rirl_dp #(
  parameter int DEPTH = rirl_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rirl_pkg::in_t      in_data,
  input  wire rirl_pkg::dp_ctrl_t ctrl,
  output      rirl_pkg::dp_stat_t stat,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      rirl_pkg::out_t     out_data
);

  import rirl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > RANK_W) ? FW : RANK_W;

  in_t               item;
  logic [FW-1:0]     fill;
  logic [AW-1:0]     src;
  logic [AW-1:0]     wr_dst;
  logic              pend;
  logic [STAT_W-1:0] stat_q;
  logic [ELEM_W-1:0] data_q;

  logic [CW-1:0]     rank_ext;
  logic [CW-1:0]     fill_ext;
  logic [CW-1:0]     rank_p1;
  logic [CW-1:0]     fill_m1;
  logic [AW-1:0]     rank_a;
  logic [STAT_W-1:0] status_c;
  logic              is_insert;
  logic              ok_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ELEM_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  assign rank_ext  = CW'(item.rank);
  assign fill_ext  = CW'(fill);
  assign rank_p1   = CW'(rank_ext + CW'(1));
  assign fill_m1   = CW'(fill_ext - CW'(1));
  assign rank_a    = rank_ext[AW-1:0];
  assign is_insert = (item.cmd == CMD_INSERT);
  assign ok_q      = (stat_q == ST_OK);

  // Bounds and capacity check of the held command.
  always_comb begin
    status_c = ST_OK;
    if (is_insert) begin
      if (rank_ext > fill_ext) begin
        status_c = ST_RANGE;
      end else if (fill_ext == CW'(DEPTH)) begin
        status_c = ST_FULL;
      end
    end else if (rank_ext >= fill_ext) begin
      status_c = ST_RANGE;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.cmd        = item.cmd;
    stat.err        = (status_c != ST_OK);
    stat.no_shift   = is_insert ? (rank_ext == fill_ext) : (rank_p1 == fill_ext);
    stat.shift_last = is_insert ? (src == rank_a) : (src == fill_m1[AW-1:0]);
    stat.slot_free  = !out_valid || out_ready;
  end

  // RAM port selection: moved entries first, then the final write.
  always_comb begin
    ram_raddr = ctrl.shift_step ? src : rank_a;
    ram_we    = 1'b0;
    ram_waddr = rank_a;
    ram_wdata = item.elem;
    if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = wr_dst;
      ram_wdata = ram_rdata;
    end else if (ctrl.commit && ok_q &&
                 (item.cmd inside {CMD_INSERT, CMD_REPLACE})) begin
      ram_we = 1'b1;
    end
  end

  rirl_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Held command, status and shift walker.
  always_ff @(posedge clk) begin
    if (ctrl.latch_item) begin
      item <= in_data;
    end
    if (ctrl.eval) begin
      stat_q <= status_c;
    end
    if (ctrl.start_shift) begin
      src <= is_insert ? fill_m1[AW-1:0] : rank_p1[AW-1:0];
    end else if (ctrl.shift_step) begin
      src    <= is_insert ? AW'(src - AW'(1)) : AW'(src + AW'(1));
      wr_dst <= is_insert ? AW'(src + AW'(1)) : AW'(src - AW'(1));
    end
    if (ctrl.commit) begin
      data_q <= (ok_q && item.cmd == CMD_READ) ? ram_rdata : '0;
    end
    if (ctrl.load_result) begin
      out_data.data_out <= data_q;
      out_data.count    <= fill_ext[CNT_W-1:0];
      out_data.status   <= stat_q;
    end
  end

  // Control registers: pending write-back, fill count, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= ctrl.shift_step;
      if (ctrl.commit && ok_q) begin
        if (item.cmd == CMD_INSERT) begin
          fill <= FW'(fill + FW'(1));
        end else if (item.cmd == CMD_REMOVE) begin
          fill <= FW'(fill - FW'(1));
        end
      end
      if (ctrl.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ranked_insert_remove_list.sv
// Top level of the ranked insert/remove list: controller plus datapath.
// Depends on rirl_pkg, rirl_ctrl and rirl_dp (which holds rirl_ram).
//
//   Port group   Direction  Beat type  Handshake
//   in_*         input      in_t       in_valid / in_ready
//   out_*        output     out_t      out_valid / out_ready
//
// A read, replace, append, tail remove or rejected command passes the idle,
// eval, commit and finish states. An insert or remove that moves m entries
// adds the shift and drain states, one entry per cycle through the single
// write port of the entry RAM. Reset clears the fill count and the handshake
// state; entry contents stay undefined until written. A stalled result waits
// in the output register, and the next command is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

module ranked_insert_remove_list #(
  parameter int DEPTH = rirl_pkg::DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire rirl_pkg::in_t  in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      rirl_pkg::out_t out_data
);

  import rirl_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rirl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rirl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One command is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while another is in flight");

  // Only a successful read returns data.
  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.data_out != '0) |-> (out_data.status == ST_OK))
    else $error("nonzero data on a failed command");

  // A full status reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.count == CNT_W'(DEPTH)))
    else $error("full status with list not full");

endmodule

`default_nettype wire

// File: verif/tb_ranked_insert_remove_list.sv
// Self-checking testbench for the ranked insert/remove list.
// Depends on rirl_pkg and on the ranked_insert_remove_list top level only.
`timescale 1ns / 1ps

module tb_ranked_insert_remove_list;
  import rirl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_FREE,
    ROW_TYPED,
    ROW_FILL
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_t       beat;
    out_t      want;
  } cmd_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Shadow copy of the list and the results still owed by the block.
  logic [ELEM_W-1:0] list_mem [DEPTH];
  int   list_fill;
  out_t owed_results [$];

  // Traffic shaping shared between the sender and the receiver.
  int idle_tab  [4] = '{0, 64, 0, 20};
  int stall_tab [4] = '{0, 0, 64, 20};
  int idle_pct;
  int stall_pct;
  int hold_asked;
  bit growing;

  // Run statistics.
  int errors;
  int n_cmds;
  int n_beats;
  int n_ok;
  int n_range;
  int n_full;
  int peak_fill;

  cmd_row_t dir_rows [$];

  ranked_insert_remove_list #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic out_t list_update(input in_t c);
    out_t r;
    int   i;
    r = '0;
    r.status = ST_OK;
    if (c.cmd == CMD_INSERT) begin
      if (int'(c.rank) > list_fill) begin
        r.status = ST_RANGE;
      end else if (list_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (i = list_fill; i > int'(c.rank); i--) list_mem[i] = list_mem[i-1];
        list_mem[c.rank] = c.elem;
        list_fill++;
      end
    end else if (int'(c.rank) >= list_fill) begin
      r.status = ST_RANGE;
    end else if (c.cmd == CMD_READ) begin
      r.data_out = list_mem[c.rank];
    end else if (c.cmd == CMD_REPLACE) begin
      list_mem[c.rank] = c.elem;
    end else begin
      for (i = int'(c.rank); i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
      list_fill--;
    end
    r.count = CNT_W'(list_fill);
    return r;
  endfunction

  function automatic cmd_row_t mk_row(input row_kind_t kind, input logic [CMD_W-1:0] cmd,
                                      input logic [RANK_W-1:0] rank,
                                      input logic [ELEM_W-1:0] elem,
                                      input logic [ELEM_W-1:0] dout,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [STAT_W-1:0] st);
    cmd_row_t r;
    r.kind = kind;
    r.beat.cmd = cmd;
    r.beat.rank = rank;
    r.beat.elem = elem;
    r.want.data_out = dout;
    r.want.count = cnt;
    r.want.status = st;
    return r;
  endfunction

  // Idle cycles before the next beat, drawn per cycle at the current idle rate.
  function automatic int sender_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  // Random command that mostly addresses valid ranks, drifting the list between
  // empty and full, with some out-of-bounds ranks mixed in.
  function automatic in_t rand_cmd();
    in_t c;
    int  pick;
    int  lim;
    if (list_fill == 0) begin
      growing = 1'b1;
    end else if (list_fill == DEPTH && $urandom_range(3) == 0) begin
      growing = 1'b0;
    end else if ($urandom_range(49) == 0) begin
      growing = !growing;
    end
    pick = $urandom_range(99);
    if (pick < 45) c.cmd = growing ? CMD_INSERT : CMD_REMOVE;
    else if (pick < 60) c.cmd = CMD_READ;
    else if (pick < 75) c.cmd = CMD_REPLACE;
    else c.cmd = growing ? CMD_REMOVE : CMD_INSERT;
    lim = (c.cmd == CMD_INSERT) ? list_fill : list_fill - 1;
    pick = $urandom_range(99);
    if (pick < 10 || lim < 0) c.rank = RANK_W'($urandom_range(127));
    else if (pick < 20) c.rank = '0;
    else if (pick < 30) c.rank = RANK_W'(lim);
    else c.rank = RANK_W'($urandom_range(lim));
    c.elem = ELEM_W'($urandom_range(255));
    return c;
  endfunction

  // Offers one beat, waits for it to be taken, then records its expected result.
  task automatic offer(input in_t beat, input bit typed, input out_t typed_res);
    int   gap;
    out_t predicted;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = list_update(beat);
    owed_results.push_back(typed ? typed_res : predicted);
    n_cmds++;
    if (list_fill > peak_fill) peak_fill = list_fill;
  endtask

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker: each accepted result beat is matched against the oldest owed one.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      n_beats++;
      case (out_data.status)
        ST_OK:    n_ok++;
        ST_RANGE: n_range++;
        ST_FULL:  n_full++;
        default:  ;
      endcase
      if (owed_results.size() == 0) begin
        $display("%0t ns: result beat with nothing owed, got %02h/%0d/%0d", $time,
                 out_data.data_out, out_data.count, out_data.status);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.data_out !== want.data_out) begin
          $display("%0t ns: data_out expected %02h, got %02h", $time, want.data_out,
                   out_data.data_out);
          errors++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t ns: count expected %0d, got %0d", $time, want.count, out_data.count);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t ns: status expected %0d, got %0d", $time, want.status,
                   out_data.status);
          errors++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #16_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Main stimulus: reset, directed table, then random phases.
  initial begin
    int   p;
    int   n;
    in_t  c;
    out_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    list_fill = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_asked = 0;
    growing = 1'b1;
    errors = 0;
    n_cmds = 0;
    n_beats = 0;
    n_ok = 0;
    n_range = 0;
    n_full = 0;
    peak_fill = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list, then a few entries, then a full list.
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd0,   8'h00, 8'h00, 7'd0, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REPLACE, 7'd0,   8'hff, 8'h00, 7'd0, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd0,   8'h00, 8'h00, 7'd0, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd1,   8'h33, 8'h00, 7'd0, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd127, 8'hff, 8'h00, 7'd0, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd0,   8'hff, 8'h00, 7'd1, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd1,   8'h00, 8'h00, 7'd2, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd0,   8'ha5, 8'h00, 7'd3, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd0,   8'h00, 8'ha5, 7'd3, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd1,   8'h00, 8'hff, 7'd3, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd2,   8'hff, 8'h00, 7'd3, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd3,   8'h00, 8'h00, 7'd3, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REPLACE, 7'd1,   8'h5a, 8'h00, 7'd3, ST_OK));
    dir_rows.push_back(mk_row(ROW_FREE,  CMD_READ,    7'd1,   8'h00, 8'h00, 7'd0, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd0,   8'h00, 8'h00, 7'd2, ST_OK));
    dir_rows.push_back(mk_row(ROW_FREE,  CMD_READ,    7'd0,   8'h00, 8'h00, 7'd0, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd1,   8'h00, 8'h00, 7'd1, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REPLACE, 7'd127, 8'hff, 8'h00, 7'd1, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd64,  8'h00, 8'h00, 7'd1, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_FILL,  CMD_INSERT,  7'd0,   8'h00, 8'h00, 7'd0, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd64,  8'h11, 8'h00, 7'd64, ST_FULL));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd0,   8'h22, 8'h00, 7'd64, ST_FULL));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_INSERT,  7'd65,  8'h44, 8'h00, 7'd64, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_FREE,  CMD_READ,    7'd63,  8'h00, 8'h00, 7'd0, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd64,  8'h00, 8'h00, 7'd64, ST_RANGE));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REPLACE, 7'd63,  8'hff, 8'h00, 7'd64, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_READ,    7'd63,  8'h00, 8'hff, 7'd64, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd0,   8'h00, 8'h00, 7'd63, ST_OK));
    dir_rows.push_back(mk_row(ROW_TYPED, CMD_REMOVE,  7'd62,  8'h00, 8'h00, 7'd62, ST_OK));

    // Walk the directed table; a fill row inserts at random ranks until full.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_FILL) begin
        while (list_fill < DEPTH) begin
          c.cmd = CMD_INSERT;
          c.rank = RANK_W'($urandom_range(list_fill));
          c.elem = ELEM_W'($urandom_range(255));
          offer(c, 1'b0, none);
        end
      end else begin
        offer(dir_rows[i].beat, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
      end
    end

    // Random phases with different idle and stall rates.
    for (p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Long receiver hold-off while the sender keeps pushing.
        if (p == 0 && n == 40) hold_asked++;
        offer(rand_cmd(), 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d result beats; peak list size %0d.",
             n_cmds, n_beats, peak_fill);
    $display("Result status mix: %0d ok, %0d rank out of bounds, %0d list full.",
             n_ok, n_range, n_full);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
